// File: design/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// Types and constants shared by the nearest neighbor tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;

    localparam int POINTS_DEF = 32;
    localparam int LEN_W      = 23;
    localparam int SQ_W       = 34;
    localparam int ROOT_W     = 17;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_CITY  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0]       city_index;
        logic [LEN_W-1:0] running_length;
        logic             last;
    } t_out;

    // Squared distance of two points, exact.
    function automatic logic [SQ_W-1:0] sq_dist(input logic signed [15:0] ax,
                                                input logic signed [15:0] ay,
                                                input logic signed [15:0] bx,
                                                input logic signed [15:0] by);
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [16:0]        ux;
        logic [16:0]        uy;
        dx = 17'(ax) - 17'(bx);
        dy = 17'(ay) - 17'(by);
        ux = dx[16] ? 17'(-dx) : 17'(dx);
        uy = dy[16] ? 17'(-dy) : 17'(dy);
        return SQ_W'(ux * ux) + SQ_W'(uy * uy);
    endfunction

endpackage

// File: design/nnt_cell.sv
// ----------------------------------------------------------------------------
// nnt_cell
// One point slot: holds a point and its visited mark, and passes the best
// candidate found so far to the next slot.
// ----------------------------------------------------------------------------
module nnt_cell #(
    parameter int IDX_W = 5,
    parameter logic [IDX_W-1:0] IDX = '0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic signed [15:0]           i_wx,
    input  logic signed [15:0]           i_wy,
    input  logic                         i_en,
    input  logic                         i_clr_mark,
    input  logic                         i_mark,
    input  logic signed [15:0]           i_gx,
    input  logic signed [15:0]           i_gy,
    input  logic                         i_found,
    input  logic [nnt_pkg::SQ_W-1:0]     i_bd,
    input  logic [IDX_W-1:0]             i_bi,
    output logic signed [15:0]           o_gx,
    output logic signed [15:0]           o_gy,
    output logic                         o_found,
    output logic [nnt_pkg::SQ_W-1:0]     o_bd,
    output logic [IDX_W-1:0]             o_bi,
    output logic signed [15:0]           o_px,
    output logic signed [15:0]           o_py
);
    logic signed [15:0]       r_px, r_py;
    logic                     r_vis;
    logic [nnt_pkg::SQ_W-1:0] w_d;
    logic                     w_take;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_px <= i_wx;
            r_py <= i_wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr_mark) begin
            r_vis <= 1'b0;
        end else if (i_mark) begin
            r_vis <= 1'b1;
        end
    end

    assign w_d    = nnt_pkg::sq_dist(i_gx, i_gy, r_px, r_py);
    assign w_take = i_en && !r_vis && (!i_found || w_d < i_bd);

    // Register the candidate toward the next slot.
    always_ff @(posedge i_clk) begin
        o_gx    <= i_gx;
        o_gy    <= i_gy;
        o_found <= i_found || w_take;
        o_bd    <= w_take ? w_d : i_bd;
        o_bi    <= w_take ? IDX : i_bi;
    end

    assign o_px = r_px;
    assign o_py = r_py;
endmodule

// File: design/nnt_isqrt.sv
// ----------------------------------------------------------------------------
// nnt_isqrt
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nnt_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nnt_pkg::SQ_W-1:0]   i_v,
    output logic                       o_done,
    output logic [nnt_pkg::ROOT_W-1:0] o_root
);
    localparam int CW = $clog2(nnt_pkg::ROOT_W + 1);
    logic [nnt_pkg::SQ_W+1:0]   r_rem;
    logic [nnt_pkg::SQ_W+1:0]   r_val;
    logic [nnt_pkg::ROOT_W-1:0] r_q;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic [nnt_pkg::SQ_W+1:0]   w_rem, w_trial;

    assign w_rem   = {r_rem[nnt_pkg::SQ_W-1:0], r_val[nnt_pkg::SQ_W+1:nnt_pkg::SQ_W]};
    assign w_trial = {(nnt_pkg::SQ_W - nnt_pkg::ROOT_W)'(0), r_q, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                // Left-align the operand so the top bit pair feeds the first step.
                r_val  <= {i_v, 2'b00};
                r_q    <= '0;
                r_cnt  <= CW'(nnt_pkg::ROOT_W);
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (w_rem >= w_trial) begin
                    r_rem <= w_rem - w_trial;
                    r_q   <= {r_q[nnt_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem;
                    r_q   <= {r_q[nnt_pkg::ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_root = r_q;
endmodule

// File: design/nearest_neighbor_tour_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top
// Greedy nearest neighbor tour over a store of planar points.
// ----------------------------------------------------------------------------
// A run on N points makes N searches of the chain of POINTS slots (one slot per
// cycle) and N leg steps (distance, bit-serial root of 17 steps plus handoff,
// output), and an output step waits while the output register is full; the
// slot chain and the bit-serial root set the run time.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_top #(
    parameter int POINTS = nnt_pkg::POINTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  nnt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output nnt_pkg::t_out o_data
);
    localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CW = $clog2(POINTS + 1);
    localparam int SW = $clog2(POINTS + 2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_RWAIT = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_st;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_step;
    logic [SW-1:0] r_sc;
    logic [IW-1:0] r_cur, r_start, r_next;
    logic [nnt_pkg::LEN_W-1:0] r_len;
    logic r_first, r_close;
    logic r_ov;
    nnt_pkg::t_out r_out;

    logic signed [15:0] w_gx [POINTS+1];
    logic signed [15:0] w_gy [POINTS+1];
    logic               w_f  [POINTS+1];
    logic [nnt_pkg::SQ_W-1:0] w_bd [POINTS+1];
    logic [IW-1:0]      w_bi [POINTS+1];
    logic signed [15:0] w_px [POINTS];
    logic signed [15:0] w_py [POINTS];
    logic [POINTS-1:0]  w_mark;
    logic               w_acc, w_clrm, w_sq_go, w_sq_done;
    logic [nnt_pkg::ROOT_W-1:0] w_root;
    logic [nnt_pkg::SQ_W-1:0]   r_sq;
    logic [nnt_pkg::LEN_W:0]    w_sum;

    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign w_clrm  = w_acc && (i_data.cmd == nnt_pkg::CMD_RUN);

    assign w_gx[0] = r_first ? 16'sd0 : w_px[r_cur];
    assign w_gy[0] = r_first ? 16'sd0 : w_py[r_cur];
    assign w_f[0]  = 1'b0;
    assign w_bd[0] = '0;
    assign w_bi[0] = '0;

    for (genvar g = 0; g < POINTS; g++) begin : g_cell
        nnt_cell #(.IDX_W(IW), .IDX(IW'(g))) u_cell (
            .i_clk, .i_rst_n,
            .i_wr(w_acc && i_data.cmd == nnt_pkg::CMD_LOAD && r_cnt == CW'(g)),
            .i_wx(i_data.pos_x), .i_wy(i_data.pos_y),
            .i_en(r_st == S_SRCH && r_sc == SW'(g) && CW'(g) < r_cnt),
            .i_clr_mark(w_clrm),
            .i_mark(w_mark[g]),
            .i_gx(w_gx[g]), .i_gy(w_gy[g]), .i_found(w_f[g]),
            .i_bd(w_bd[g]), .i_bi(w_bi[g]),
            .o_gx(w_gx[g+1]), .o_gy(w_gy[g+1]), .o_found(w_f[g+1]),
            .o_bd(w_bd[g+1]), .o_bi(w_bi[g+1]),
            .o_px(w_px[g]), .o_py(w_py[g])
        );
        assign w_mark[g] = (r_st == S_WAIT) && (w_bi[POINTS] == IW'(g));
    end

    assign w_sq_go = (r_st == S_ROOT);
    nnt_isqrt u_root (
        .i_clk, .i_rst_n, .i_start(w_sq_go), .i_v(r_sq),
        .o_done(w_sq_done), .o_root(w_root)
    );
    assign w_sum = (nnt_pkg::LEN_W+1)'(r_len) + (nnt_pkg::LEN_W+1)'(w_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_data.cmd)
                            nnt_pkg::CMD_LOAD: begin
                                if (r_cnt == CW'(POINTS)) begin
                                    r_out <= '{nnt_pkg::ST_FULL, 6'd0, '0, 1'b1};
                                    r_ov  <= 1'b1;
                                end else begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                            end
                            nnt_pkg::CMD_CLEAR: r_cnt <= '0;
                            nnt_pkg::CMD_RUN: begin
                                if (r_cnt == '0) begin
                                    r_out <= '{nnt_pkg::ST_EMPTY, 6'd0, '0, 1'b1};
                                    r_ov  <= 1'b1;
                                end else begin
                                    r_first <= 1'b1;
                                    r_len   <= '0;
                                    r_step  <= CW'(1);
                                    r_sc    <= '0;
                                    r_st    <= S_SRCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // Walk the candidate through all slots, one per cycle.
                S_SRCH: begin
                    r_sc <= r_sc + 1'b1;
                    if (r_sc == SW'(POINTS - 1)) r_st <= S_WAIT;
                end
                S_WAIT: begin
                    r_next <= w_bi[POINTS];
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_cur   <= w_bi[POINTS];
                        r_start <= w_bi[POINTS];
                        if (r_cnt == CW'(1)) begin
                            r_close <= 1'b1;
                            r_st    <= S_EMIT;
                        end else begin
                            r_sc <= '0;
                            r_st <= S_SRCH;
                        end
                    end else begin
                        r_close <= 1'b0;
                        r_st    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_sq <= nnt_pkg::sq_dist(w_px[r_cur], w_py[r_cur],
                                             w_px[r_close ? r_start : r_next],
                                             w_py[r_close ? r_start : r_next]);
                    r_st <= S_ROOT;
                end
                S_ROOT: r_st <= S_RWAIT;
                S_RWAIT: begin
                    if (w_sq_done) r_st <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        if (r_close) begin
                            r_out <= '{nnt_pkg::ST_CITY, 6'(r_cur),
                                       w_sum[nnt_pkg::LEN_W] ? '1 : w_sum[nnt_pkg::LEN_W-1:0],
                                       1'b1};
                            r_st  <= S_IDLE;
                        end else begin
                            r_out  <= '{nnt_pkg::ST_CITY, 6'(r_cur), r_len, 1'b0};
                            r_len  <= w_sum[nnt_pkg::LEN_W] ? '1 : w_sum[nnt_pkg::LEN_W-1:0];
                            r_cur  <= r_next;
                            r_step <= r_step + 1'b1;
                            if (r_step + 1'b1 == r_cnt) begin
                                r_close <= 1'b1;
                                r_st    <= S_EMIT;
                            end else begin
                                r_sc <= '0;
                                r_st <= S_SRCH;
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Nearest neighbor tour block: directed table of loads, runs and clears with
// typed-in results for the simple cases, a filled and overflowed store, then
// random point sets and tours, all checked in order against a behavioral tour builder.
// ----------------------------------------------------------------------------
module tb;

    localparam int         NPTS       = 32;
    localparam logic [1:0] CMD_NOP    = 2'd3;
    localparam int         IDLE_MAX   = 200000;
    localparam int         RAND_ITEMS = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    nnt_pkg::t_in  i_data;
    logic o_valid;
    logic i_stall;
    nnt_pkg::t_out o_data;

    nearest_neighbor_tour_top #(.POINTS(NPTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // tour builder state
    logic signed [15:0] store_x [NPTS];
    logic signed [15:0] store_y [NPTS];
    int unsigned        store_cnt;

    nnt_pkg::t_out tour_q [$];
    int   errors;
    int   idle_cycles;
    bit   long_hold;

    function automatic longint unsigned dist2(logic signed [15:0] ax, logic signed [15:0] ay,
                                              logic signed [15:0] bx, logic signed [15:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic int unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return 32'(r);
    endfunction

    function automatic int unsigned closest(logic signed [15:0] gx, logic signed [15:0] gy,
                                            bit [NPTS-1:0] seen);
        int unsigned     best;
        longint unsigned bd;
        longint unsigned d;
        bit              got;
        best = 0; bd = 0; got = 0;
        for (int i = 0; i < store_cnt; i++) begin
            if (!seen[i]) begin
                d = dist2(gx, gy, store_x[i], store_y[i]);
                if (!got || d < bd) begin
                    best = i; bd = d; got = 1;
                end
            end
        end
        return best;
    endfunction

    function automatic nnt_pkg::t_out mk(logic [1:0] st, int unsigned c, int unsigned len,
                                         bit l);
        nnt_pkg::t_out r;
        r.status = st;
        r.city_index = 6'(c);
        r.running_length = nnt_pkg::LEN_W'(len);
        r.last = l;
        return r;
    endfunction

    task automatic build_tour(input nnt_pkg::t_in item);
        bit [NPTS-1:0] seen;
        int unsigned   start;
        int unsigned   cur;
        int unsigned   nxt;
        longint unsigned len;
        unique case (item.cmd)
            nnt_pkg::CMD_LOAD: begin
                if (store_cnt >= NPTS) begin
                    tour_q.push_back(mk(nnt_pkg::ST_FULL, 0, 0, 1'b1));
                end else begin
                    store_x[store_cnt] = item.pos_x;
                    store_y[store_cnt] = item.pos_y;
                    store_cnt++;
                end
            end
            nnt_pkg::CMD_CLEAR: store_cnt = 0;
            nnt_pkg::CMD_RUN: begin
                if (store_cnt == 0) begin
                    tour_q.push_back(mk(nnt_pkg::ST_EMPTY, 0, 0, 1'b1));
                end else begin
                    seen = '0;
                    len = 0;
                    start = closest(16'sd0, 16'sd0, seen);
                    cur = start;
                    seen[start] = 1'b1;
                    for (int k = 1; k < store_cnt; k++) begin
                        nxt = closest(store_x[cur], store_y[cur], seen);
                        tour_q.push_back(mk(nnt_pkg::ST_CITY, cur, 32'(len), 1'b0));
                        len += root_floor(dist2(store_x[cur], store_y[cur],
                                                store_x[nxt], store_y[nxt]));
                        if (len > 8388607) len = 8388607;
                        seen[nxt] = 1'b1;
                        cur = nxt;
                    end
                    len += root_floor(dist2(store_x[cur], store_y[cur],
                                            store_x[start], store_y[start]));
                    if (len > 8388607) len = 8388607;
                    tour_q.push_back(mk(nnt_pkg::ST_CITY, cur, 32'(len), 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    // directed table: typed result used where has_exp is set
    typedef struct {
        nnt_pkg::t_in  item;
        bit            has_exp;
        nnt_pkg::t_out exp_res;
    } t_row;

    t_row          dir_rows [$];
    nnt_pkg::t_out typed_q [$];
    bit            typed_flag [$];

    function automatic nnt_pkg::t_in itm(logic [1:0] c, int x, int y);
        nnt_pkg::t_in r;
        r.cmd = c;
        r.pos_x = 16'(x);
        r.pos_y = 16'(y);
        return r;
    endfunction

    task automatic send(input nnt_pkg::t_in item);
        i_data <= item;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        build_tour(item);
        @(negedge i_clk);
    endtask

    task automatic gap_maybe(input int unsigned chance);
        int unsigned g;
        if ($urandom_range(99) < chance) begin
            i_valid <= 1'b0;
            i_data <= itm(2'($urandom_range(3)), $urandom, $urandom);
            g = $urandom_range(1, 8);
            repeat (g) @(negedge i_clk);
        end
    endtask

    // receiver: own stall pattern, plus one long hold-off
    initial begin
        int unsigned pat;
        i_stall = 1'b0;
        long_hold = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold && tour_q.size() > 10) begin
                long_hold = 1'b1;
                i_stall <= 1'b1;
                repeat (3000) @(negedge i_clk);
            end
            pat = $urandom_range(99);
            i_stall <= (pat < 30);
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            idle_cycles <= 0;
            if (tour_q.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, o_data);
                errors++;
            end else begin
                nnt_pkg::t_out e;
                e = tour_q.pop_front();
                if (typed_flag.size() != 0 && typed_flag.pop_front()) begin
                    if (typed_q[0] != e) begin
                        $display("%0t table row disagrees: expected %p actual %p",
                                 $time, typed_q[0], e);
                        errors++;
                    end
                    void'(typed_q.pop_front());
                end
                if (o_data.status !== e.status || o_data.city_index !== e.city_index ||
                    o_data.running_length !== e.running_length ||
                    o_data.last !== e.last) begin
                    $display("%0t mismatch: expected %p actual %p", $time, e, o_data);
                    errors++;
                end
            end
        end else if (i_valid && !o_stall) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_MAX) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned sz;
        int unsigned q0;
        t_row r;
        errors = 0;
        idle_cycles = 0;
        store_cnt = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = itm(nnt_pkg::CMD_CLEAR, 0, 0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // run after reset, one-point tour, extremes, ties, ignored command, run after clear
        r.has_exp = 1; r.item = itm(nnt_pkg::CMD_RUN, 0, 0);
        r.exp_res = mk(nnt_pkg::ST_EMPTY, 0, 0, 1'b1);
        dir_rows.push_back(r);
        r.has_exp = 0;
        r.item = itm(nnt_pkg::CMD_LOAD, -32768, 32767); dir_rows.push_back(r);
        r.has_exp = 1; r.item = itm(nnt_pkg::CMD_RUN, 0, 0);
        r.exp_res = mk(nnt_pkg::ST_CITY, 0, 0, 1'b1);
        dir_rows.push_back(r);
        r.has_exp = 0;
        r.item = itm(nnt_pkg::CMD_LOAD, 32767, -32768); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_LOAD, -32768, -32768); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_LOAD, 32767, 32767); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_LOAD, 16, 0); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_LOAD, -16, 0); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_LOAD, 0, 16); dir_rows.push_back(r);
        r.item = itm(CMD_NOP, 5, 5); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_RUN, 0, 0); dir_rows.push_back(r);
        r.item = itm(nnt_pkg::CMD_CLEAR, 0, 0); dir_rows.push_back(r);
        r.has_exp = 1; r.item = itm(nnt_pkg::CMD_RUN, 0, 0);
        r.exp_res = mk(nnt_pkg::ST_EMPTY, 0, 0, 1'b1);
        dir_rows.push_back(r);

        foreach (dir_rows[i]) begin
            q0 = tour_q.size();
            send(dir_rows[i].item);
            for (int k = q0; k < tour_q.size(); k++) begin
                typed_flag.push_back(dir_rows[i].has_exp);
                if (dir_rows[i].has_exp) typed_q.push_back(dir_rows[i].exp_res);
            end
        end
        // fill the store to the top, then overflow it and run a full tour
        for (int k = 0; k < NPTS + 2; k++) begin
            send(itm(nnt_pkg::CMD_LOAD, $urandom, $urandom));
            gap_maybe(20);
        end
        send(itm(nnt_pkg::CMD_RUN, 0, 0));
        send(itm(nnt_pkg::CMD_CLEAR, 0, 0));

        // random: mostly load a set then run it, sometimes noise
        n = 0;
        while (n < RAND_ITEMS) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(1, NPTS) : $urandom_range(1, 6);
            for (int k = 0; k < sz; k++) begin
                if ($urandom_range(1))
                    send(itm(nnt_pkg::CMD_LOAD, $urandom, $urandom));
                else
                    send(itm(nnt_pkg::CMD_LOAD, $urandom_range(64) - 32,
                             $urandom_range(64) - 32));
                n++;
                gap_maybe(25);
            end
            if ($urandom_range(9) == 0) begin
                send(itm(2'($urandom_range(3)), $urandom, $urandom));
                n++;
            end
            send(itm(nnt_pkg::CMD_RUN, $urandom, $urandom));
            n++;
            if ($urandom_range(3) != 0) begin
                send(itm(nnt_pkg::CMD_CLEAR, $urandom, $urandom));
                n++;
            end
            gap_maybe(40);
        end
        i_valid <= 1'b0;

        while (tour_q.size() != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

// File: nearest_neighbor_tour_top.f
design/nnt_pkg.sv
design/nnt_cell.sv
design/nnt_isqrt.sv
design/nearest_neighbor_tour_top.sv
tb/sv/tb.sv
